### src/rast_pkg.sv
// Shared types and constants for the range add / range sum tree.
// No dependencies; imported by rast_engine and the top level.
package rast_pkg;

    localparam int IDX_W   = 10;   // element index width
    localparam int CNT_W   = 11;   // element count register width
    localparam int NODE_W  = 12;   // tree node address width
    localparam int DATA_W  = 64;
    localparam int STK_W   = 4;    // frame stack pointer width
    localparam int MAX_ELEMENTS = 1024;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [IDX_W-1:0]    left;
        logic [IDX_W-1:0]    right;
        logic [DATA_W-1:0]   value;   // sign-extended add amount
    } cmd_t;

    typedef struct packed {
        logic ready;          // engine idle, can take a command
        logic result_valid;   // query sum presented this cycle
    } eng_status_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic              right_done;
    } frame_t;

    function automatic logic [IDX_W-1:0] mid_of(logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
        logic [IDX_W:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[IDX_W:1];
    endfunction

    function automatic logic [NODE_W-1:0] left_child(logic [NODE_W-1:0] k);
        return {k[NODE_W-2:0], 1'b0};
    endfunction

    function automatic logic [NODE_W-1:0] right_child(logic [NODE_W-1:0] k);
        return {k[NODE_W-2:0], 1'b1};
    endfunction

endpackage

### src/rast_engine.sv
// Sequencer and node memory of the lazy segment tree.
// Depends on rast_pkg. One memory holds {pending tag, subtree sum} per node.
module rast_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  rast_pkg::cmd_t          cmd,
    input  logic [rast_pkg::IDX_W-1:0] last,
    input  logic                    res_free,
    output rast_pkg::eng_status_t   status,
    output logic [rast_pkg::DATA_W-1:0] result
);
    import rast_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_CLR, E_VISIT, E_CALC, E_MUL, E_WRK, E_CH1, E_CH2,
        E_DECIDE, E_POP, E_PS1, E_PS2, E_PS3, E_DONE
    } state_t;

    state_t               state_reg;
    action_t              act_reg;
    logic [IDX_W-1:0]     l_reg, r_reg;
    logic [DATA_W-1:0]    val_reg;
    logic [NODE_W-1:0]    cur_reg, par_reg, clr_cnt_reg;
    logic [IDX_W-1:0]     lo_reg, hi_reg;
    logic [STK_W-1:0]     sp_reg;
    logic [DATA_W-1:0]    eff_reg, sum_reg, prod_reg, nsum_reg, suml_reg, acc_reg;

    logic [2*DATA_W-1:0]  mem [2**NODE_W];
    logic [2*DATA_W-1:0]  rd_data_reg, wr_data;
    logic [NODE_W-1:0]    rd_addr, wr_addr;
    logic                 wr_en;

    frame_t               stack [2**STK_W];
    frame_t               top, stk_wd;
    logic [STK_W-1:0]     top_idx, stk_wa;
    logic                 stk_we;

    logic [DATA_W-1:0]    rd_tag, rd_sum;
    logic [IDX_W:0]       len;
    logic [DATA_W+IDX_W:0] prod_full;
    logic                 covered, disjoint;
    logic [IDX_W-1:0]     r_clip, cur_mid, top_mid;

    assign rd_tag   = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_sum   = rd_data_reg[DATA_W-1:0];
    assign len      = {1'b0, hi_reg} - {1'b0, lo_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign prod_full = eff_reg * len;
    assign covered  = (lo_reg >= l_reg) && (hi_reg <= r_reg);
    assign disjoint = (hi_reg < l_reg) || (r_reg < lo_reg);
    assign r_clip   = (cmd.right > last) ? last : cmd.right;
    assign top_idx  = sp_reg - 1'b1;
    assign top      = stack[top_idx];
    assign cur_mid  = mid_of(lo_reg, hi_reg);
    assign top_mid  = mid_of(top.lo, top.hi);

    assign status.ready        = (state_reg == E_IDLE);
    assign status.result_valid = (state_reg == E_DONE) && (act_reg == ACT_QUERY) && res_free;
    assign result              = acc_reg;

    // memory port control
    always_comb
    begin
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = '0;
        unique case (state_reg)
            E_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            E_WRK:
            begin
                wr_en   = 1'b1;
                wr_data = {{DATA_W{1'b0}}, sum_reg + prod_reg};
                rd_addr = left_child(cur_reg);
            end
            E_CH1:
            begin
                wr_en   = 1'b1;
                wr_addr = left_child(cur_reg);
                wr_data = {rd_tag + eff_reg, rd_sum};
                rd_addr = right_child(cur_reg);
            end
            E_CH2:
            begin
                wr_en   = 1'b1;
                wr_addr = right_child(cur_reg);
                wr_data = {rd_tag + eff_reg, rd_sum};
            end
            E_PS1:   rd_addr = left_child(par_reg);
            E_PS2:   rd_addr = right_child(par_reg);
            E_PS3:
            begin
                wr_en   = 1'b1;
                wr_addr = par_reg;
                wr_data = {{DATA_W{1'b0}}, suml_reg + rd_sum};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // frame stack: push on a split node, mark when the left half returns
    always_comb
    begin
        stk_we = 1'b0;
        stk_wa = sp_reg;
        stk_wd = '{node: cur_reg, lo: lo_reg, hi: hi_reg, right_done: 1'b0};
        if (state_reg == E_DECIDE && !disjoint && !covered)
        begin
            stk_we = 1'b1;
        end
        else if (state_reg == E_POP && sp_reg != '0 && !top.right_done)
        begin
            stk_we = 1'b1;
            stk_wa = top_idx;
            stk_wd = top;
            stk_wd.right_done = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack[stk_wa] <= stk_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_CLR;
            act_reg     <= ACT_CLEAR;
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        act_reg     <= cmd.action;
                        l_reg       <= cmd.left;
                        r_reg       <= r_clip;
                        val_reg     <= cmd.value;
                        cur_reg     <= {{(NODE_W-1){1'b0}}, 1'b1};
                        lo_reg      <= '0;
                        hi_reg      <= last;
                        sp_reg      <= '0;
                        acc_reg     <= '0;
                        clr_cnt_reg <= '0;
                        if (cmd.action == ACT_CLEAR)
                        begin
                            state_reg <= E_CLR;
                        end
                        else if ((cmd.action == ACT_ADD || cmd.action == ACT_QUERY)
                                 && cmd.left <= r_clip)
                        begin
                            state_reg <= E_VISIT;
                        end
                        else
                        begin
                            state_reg <= E_DONE;
                        end
                    end
                end
                E_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= E_DONE;
                    end
                end
                E_VISIT: state_reg <= E_CALC;
                E_CALC:
                begin
                    // pending tag plus this add when the node lies inside the range
                    eff_reg   <= rd_tag + ((covered && act_reg == ACT_ADD) ? val_reg : '0);
                    sum_reg   <= rd_sum;
                    state_reg <= E_MUL;
                end
                E_MUL:
                begin
                    prod_reg  <= prod_full[DATA_W-1:0];
                    state_reg <= E_WRK;
                end
                E_WRK:
                begin
                    nsum_reg  <= sum_reg + prod_reg;
                    state_reg <= (lo_reg == hi_reg) ? E_DECIDE : E_CH1;
                end
                E_CH1:   state_reg <= E_CH2;
                E_CH2:   state_reg <= E_DECIDE;
                E_DECIDE:
                begin
                    if (disjoint)
                    begin
                        state_reg <= E_POP;
                    end
                    else if (covered)
                    begin
                        if (act_reg == ACT_QUERY)
                        begin
                            acc_reg <= acc_reg + nsum_reg;
                        end
                        state_reg <= E_POP;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg + 1'b1;
                        cur_reg   <= left_child(cur_reg);
                        hi_reg    <= cur_mid;
                        state_reg <= E_VISIT;
                    end
                end
                E_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= E_DONE;
                    end
                    else if (!top.right_done)
                    begin
                        cur_reg   <= right_child(top.node);
                        lo_reg    <= top_mid + 1'b1;
                        hi_reg    <= top.hi;
                        state_reg <= E_VISIT;
                    end
                    else
                    begin
                        sp_reg <= top_idx;
                        if (act_reg == ACT_ADD)
                        begin
                            par_reg   <= top.node;
                            state_reg <= E_PS1;
                        end
                    end
                end
                E_PS1:   state_reg <= E_PS2;
                E_PS2:
                begin
                    suml_reg  <= rd_sum;
                    state_reg <= E_PS3;
                end
                E_PS3:   state_reg <= E_POP;
                E_DONE:
                begin
                    if (act_reg != ACT_QUERY || res_free)
                    begin
                        state_reg <= E_IDLE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

endmodule

### src/range_add_range_sum_tree_top.sv
// Range add / range sum store: stream ports, count register, result register.
// Depends on rast_pkg and rast_engine.
// One beat at a time: s_tready is low until the engine is idle again. Each
// node visited passes the visit, tag, multiply, write-back, child tag (inner
// nodes only) and decide states; each node rebuilt after an add gets the sum
// of its children written back. An empty range or unused action goes straight
// to done. Reset, like a clear, sweeps the node memory to zero before s_tready.
module range_add_range_sum_tree_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,   // element_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // left_index, right_index, add_value, pad
    input  logic [1:0]  s_tuser,       // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata        // range_sum
);
    import rast_pkg::*;

    logic [IDX_W-1:0]  last_reg;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [DATA_W-1:0] result;
    logic              res_free;
    cmd_t              cmd;
    eng_status_t       status;

    assign cmd.action = action_t'(s_tuser);
    assign cmd.left   = s_tdata[9:0];
    assign cmd.right  = s_tdata[19:10];
    assign cmd.value  = {{32{s_tdata[51]}}, s_tdata[51:20]};
    assign res_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = status.ready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    rast_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_tvalid && s_tready),
        .cmd      (cmd),
        .last     (last_reg),
        .res_free (res_free),
        .status   (status),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= IDX_W'(MAX_ELEMENTS - 1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // zero acts as one element, anything above the maximum as the maximum
            if (cfg_wr_en)
            begin
                if (cfg_wr_data == '0)
                begin
                    last_reg <= '0;
                end
                else if (cfg_wr_data > CNT_W'(MAX_ELEMENTS))
                begin
                    last_reg <= IDX_W'(MAX_ELEMENTS - 1);
                end
                else
                begin
                    last_reg <= IDX_W'(cfg_wr_data - 1'b1);
                end
            end
            if (status.result_valid)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.result_valid)
        begin
            m_tdata_reg <= result;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("engine stayed ready after taking a beat");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a query in progress");

endmodule
